@@ hdl/tcpr_pkg.sv @@
// Shared types, codes and constants of the Reno congestion window block.
// No dependencies; the divider, core and top level import this package.
package tcpr_pkg;

	localparam int SEG_BYTES_DEFAULT = 1024;

	localparam logic [31:0] INIT_THRESHOLD_RST = 32'd65536;
	localparam logic [15:0] SYNACK_RST         = 16'd3;

	localparam logic [2:0] DUP_FAST = 3'd3;
	localparam logic [2:0] DUP_MAX  = 3'd4;

	localparam logic MODE_ACK     = 1'b0;
	localparam logic MODE_TIMEOUT = 1'b1;

	// serial divider geometry
	localparam int DVD_W = 64;
	localparam int DVS_W = 48;
	localparam int CNT_W = 7;
	localparam logic [CNT_W-1:0] BASE_STEPS = 7'd32;
	localparam logic [CNT_W-1:0] WIN_STEPS  = 7'd64;

	typedef enum logic [1:0] {
		PH_SLOW_START    = 2'd0,
		PH_AVOID         = 2'd1,
		PH_FAST_RECOVERY = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		EV_NEW_ACK = 3'd0,
		EV_DUP     = 3'd1,
		EV_SYNACK  = 3'd2,
		EV_TIMEOUT = 3'd3,
		EV_DONE    = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		CFG_TOTAL_SIZE     = 2'd0,
		CFG_INIT_THRESHOLD = 2'd1,
		CFG_SYNACK_PATTERN = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_BASE_DIV,
		ST_GROW,
		ST_WIN_DIV,
		ST_RESULT
	} core_state_t;

	typedef struct packed {
		logic        mode;
		logic [31:0] ack_number;
		logic [15:0] flag_bits;
	} in_payload_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [1:0]  phase;
		logic [31:0] window_bytes;
		logic [31:0] threshold_bytes;
		logic [31:0] send_base_out;
		logic [31:0] next_send_out;
		logic        finished;
	} out_payload_t;

	typedef struct packed {
		logic [31:0] total_size;
		logic [15:0] synack_pattern;
		logic        thr_load;
		logic [31:0] thr_value;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
		logic [CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quotient;
		logic [DVS_W-1:0] remainder;
	} div_rsp_t;

endpackage

@@ hdl/tcpr_chan_if.sv @@
// Valid/ready channel carrying one payload beat per handshake.
// Payload type is set by the instantiating module; depends on nothing else.
interface tcpr_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/tcpr_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle, 64 by 48 bits.
// Uses div_req_t and div_rsp_t from tcpr_pkg.
module tcpr_div
	import tcpr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0]   rem_sh;
	logic [DVS_W+1:0] diff;
	logic             ge;
	logic [DVS_W-1:0] rem_nx;

	always_comb begin
		rem_sh = {rem_q, quo_q[DVD_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
		ge     = ~diff[DVS_W+1];
		rem_nx = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= req.steps;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign rsp.busy      = (cnt_q != '0);
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cnt_q) == CNT_W'(1))
		else $error("divider done without a final step");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && dvs_q != '0) |-> rem_q < dvs_q)
		else $error("divider remainder not below divisor");

endmodule

@@ hdl/tcpr_core.sv @@
// Congestion state, item sequencer and update datapath of the Reno block.
// Depends on tcpr_pkg, tcpr_chan_if and the serial divider tcpr_div.
module tcpr_core
	import tcpr_pkg::*;
#(
	parameter int SEGMENT_BYTES = SEG_BYTES_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	tcpr_chan_if.sink    in_ch,
	output logic         res_valid,
	input  logic         res_ready,
	output out_payload_t res
);

	localparam logic [15:0] SEG      = 16'(SEGMENT_BYTES);
	localparam logic [32:0] SEG3     = 33'(3 * SEGMENT_BYTES);
	localparam logic [31:0] SEG_SQ   = 32'(longint'(SEGMENT_BYTES) * longint'(SEGMENT_BYTES));
	localparam logic [47:0] WF_ONE   = {16'd0, SEG, 16'd0};

	core_state_t state_q, state_d;

	// item under work
	logic        mode_q;
	logic [31:0] ack_q;
	logic [15:0] flags_q;
	event_t      kind_q;

	// congestion state
	phase_t      phase_q;
	logic [47:0] wf_q;
	logic [31:0] thr_q;
	logic [2:0]  dup_q;
	logic [31:0] base_q;
	logic [31:0] nxt_q;
	logic        done_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [31:0] wi;
	logic        is_synack, is_final, is_dup;
	logic [2:0]  dup_inc;
	logic [32:0] fr_sum;
	logic [31:0] fr_win;
	logic [31:0] gap;
	event_t      kind_d;
	logic [15:0] rem16;
	logic [15:0] pad;
	logic [32:0] ss_sum;
	logic [31:0] ss_win;
	logic [48:0] ca_sum;
	logic        ca_sat;

	tcpr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		wi        = wf_q[47:16];
		is_synack = (flags_q == cfg.synack_pattern);
		is_final  = (ack_q >= cfg.total_size);
		is_dup    = (ack_q < base_q);
		dup_inc   = (dup_q < DUP_MAX) ? dup_q + 3'd1 : dup_q;
		fr_sum    = {1'b0, wi} + SEG3;
		fr_win    = fr_sum[32] ? '1 : fr_sum[31:0];
		gap       = ack_q - base_q;
		rem16     = div_rsp.remainder[15:0];
		pad       = (rem16 != '0) ? SEG - rem16 : '0;
		ss_sum    = {1'b0, wi} + {17'd0, SEG};
		ss_win    = ss_sum[32] ? '1 : ss_sum[31:0];
		ca_sum    = {1'b0, wf_q} + {1'b0, div_rsp.quotient[47:0]};
		ca_sat    = (|div_rsp.quotient[63:48]) | ca_sum[48];

		if (done_q) begin
			kind_d = EV_DONE;
		end else if (mode_q == MODE_TIMEOUT) begin
			kind_d = EV_TIMEOUT;
		end else if (is_synack) begin
			kind_d = EV_SYNACK;
		end else if (is_final) begin
			kind_d = EV_DONE;
		end else if (is_dup) begin
			kind_d = EV_DUP;
		end else begin
			kind_d = EV_NEW_ACK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		in_ch.ready      = 1'b0;
		res_valid        = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = {gap, 32'd0};
		div_req.divisor  = {32'd0, SEG};
		div_req.steps    = BASE_STEPS;
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (kind_d == EV_NEW_ACK) begin
					div_req.start = 1'b1;
					state_d       = ST_BASE_DIV;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_BASE_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_GROW;
				end
			end
			ST_GROW: begin
				if (phase_q == PH_SLOW_START || phase_q == PH_FAST_RECOVERY) begin
					state_d = ST_RESULT;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = {SEG_SQ, 32'd0};
					div_req.divisor  = wf_q;
					div_req.steps    = WIN_STEPS;
					state_d          = ST_WIN_DIV;
				end
			end
			ST_WIN_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			mode_q  <= in_ch.payload.mode;
			ack_q   <= in_ch.payload.ack_number;
			flags_q <= in_ch.payload.flag_bits;
		end
		if (state_q == ST_DECIDE) begin
			kind_q <= kind_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SLOW_START;
			wf_q    <= WF_ONE;
			thr_q   <= INIT_THRESHOLD_RST;
			dup_q   <= '0;
			base_q  <= '0;
			nxt_q   <= '0;
			done_q  <= 1'b0;
		end else if (cfg.thr_load) begin
			thr_q <= cfg.thr_value;
		end else begin
			case (state_q)
				ST_DECIDE: begin
					case (kind_d)
						EV_TIMEOUT: begin
							phase_q <= PH_SLOW_START;
							thr_q   <= {1'b0, wf_q[47:17]};
							wf_q    <= WF_ONE;
							dup_q   <= '0;
							nxt_q   <= base_q;
						end
						EV_DONE: begin
							done_q <= 1'b1;
						end
						EV_DUP: begin
							dup_q <= dup_inc;
							if (dup_inc == DUP_FAST && phase_q != PH_FAST_RECOVERY) begin
								phase_q <= PH_FAST_RECOVERY;
								thr_q   <= {1'b0, wf_q[47:17]};
								wf_q    <= {fr_win, 16'd0};
								nxt_q   <= base_q;
							end
						end
						default: ;
					endcase
				end
				ST_BASE_DIV: begin
					// round the advance up to a whole number of segments
					if (div_rsp.done) begin
						base_q <= ack_q + {16'd0, pad};
					end
				end
				ST_GROW: begin
					if (nxt_q < base_q) begin
						nxt_q <= base_q;
					end
					dup_q <= '0;
					case (phase_q)
						PH_SLOW_START: begin
							wf_q <= {ss_win, 16'd0};
							if (ss_win >= thr_q) begin
								phase_q <= PH_AVOID;
							end
						end
						PH_FAST_RECOVERY: begin
							phase_q <= PH_AVOID;
							wf_q    <= {thr_q, 16'd0};
						end
						default: ;
					endcase
				end
				ST_WIN_DIV: begin
					if (div_rsp.done) begin
						wf_q <= ca_sat ? '1 : ca_sum[47:0];
					end
				end
				default: ;
			endcase
		end
	end

	assign res.event_kind      = kind_q;
	assign res.phase           = phase_q;
	assign res.window_bytes    = wi;
	assign res.threshold_bytes = thr_q;
	assign res.send_base_out   = base_q;
	assign res.next_send_out   = nxt_q;
	assign res.finished        = done_q;

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> done_q)
		else $error("finished flag dropped");

	a_base_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> $stable(base_q))
		else $error("send base moved after the transfer ended");

	a_fr_dups: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FAST_RECOVERY |-> (dup_q == DUP_FAST || dup_q == DUP_MAX))
		else $error("fast recovery without three duplicates");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

endmodule

@@ hdl/tcp_reno_congestion_window.sv @@
// Reno congestion window top level: config registers, core and output register.
// Timeout, duplicate, SYN-ACK and done beats go from accept through the decide state to the result.
// New ACK: a division rounds the send base; in congestion avoidance a second one grows the window.
// The bit-serial divider runs 32 steps to round the send base, 64 for window growth.
// arst_n clears to: one-segment window, threshold 65536, SYN-ACK flags 3, total size 0.
// A result may wait in the output register while the next beat is accepted.
module tcp_reno_congestion_window
	import tcpr_pkg::*;
#(
	parameter int SEGMENT_BYTES = SEG_BYTES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	tcpr_chan_if.sink   in_ch,
	tcpr_chan_if.source out_ch
);

	logic [31:0]  total_size_q;
	logic [15:0]  synack_q;
	cfg_t         cfg;
	logic         res_valid;
	logic         res_ready;
	out_payload_t res;
	logic         out_valid_q;
	out_payload_t out_data_q;

	// the threshold register is loaded straight into the core
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_size_q <= '0;
			synack_q     <= SYNACK_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_TOTAL_SIZE:     total_size_q <= cfg_data;
				CFG_SYNACK_PATTERN: synack_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg.total_size     = total_size_q;
	assign cfg.synack_pattern = synack_q;
	assign cfg.thr_load       = cfg_write && (cfg_index == CFG_INIT_THRESHOLD);
	assign cfg.thr_value      = cfg_data;

	tcpr_core #(
		.SEGMENT_BYTES (SEGMENT_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_ch     (in_ch),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	// hold the beat until the sink takes it
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_data_q;

endmodule
